/* hw/rtl/gqg_pkg.sv */
// shared types, constants and codes of the glyph quad generator
package gqg_pkg;

    localparam int GLYPH_SLOTS_DEF = 95;
    localparam int CURSOR_BITS_DEF = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CHAR = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_FIRST   = 8'd32;
    localparam logic [7:0] CHAR_LAST    = 8'd126;

    localparam int CORNER_COUNT = 6;
    localparam logic [2:0] CORNER_LAST = 3'd5;

    localparam logic [1:0] REG_FONT_SIZE    = 2'd0;
    localparam logic [1:0] REG_ATLAS_WIDTH  = 2'd1;
    localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd2;

    localparam logic [7:0]  FONT_SIZE_RST    = 8'd32;
    localparam logic [12:0] ATLAS_WIDTH_RST  = 13'd512;
    localparam logic [12:0] ATLAS_HEIGHT_RST = 13'd512;

    localparam int UV_NUM_W = 29;
    localparam logic [16:0] UV_ONE = 17'd65536;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_CHAR,
        KIND_NEWLINE,
        KIND_OTHER
    } cmd_kind_t;

    typedef struct packed {
        logic [11:0] ax;
        logic [11:0] ay;
        logic [7:0]  gw;
        logic [7:0]  gh;
        logic [8:0]  ox;
        logic [8:0]  oy;
        logic [7:0]  adv;
    } glyph_entry_t;

    typedef struct packed {
        cmd_kind_t    kind;
        logic         start;
        logic [7:0]   slot;
        logic         no_glyph;
        glyph_entry_t entry;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIV,
        ST_EMIT
    } back_state_t;

endpackage

/* hw/rtl/gqg_div.sv */
// restoring divider, one quotient bit per cycle
module gqg_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = (cnt_reg == '0);
    assign quo  = quo_reg;

endmodule

/* hw/rtl/gqg_fifo.sv */
// two-entry command queue between front and back
module gqg_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gqg_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output gqg_pkg::cmd_t pop_cmd
);

    gqg_pkg::cmd_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full    = cnt_reg[1];
    assign empty   = (cnt_reg == 2'd0);
    assign pop_cmd = mem[rd_ptr_reg];

endmodule

/* hw/rtl/gqg_front.sv */
// input side: accepts items and turns them into queue commands
module gqg_front #(
    parameter int GLYPH_SLOTS = gqg_pkg::GLYPH_SLOTS_DEF
) (
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          op,
    input  logic [7:0]    char_code,
    input  logic          start_text,
    input  logic [11:0]   atlas_x,
    input  logic [11:0]   atlas_y,
    input  logic [7:0]    glyph_width,
    input  logic [7:0]    glyph_height,
    input  logic [8:0]    origin_x,
    input  logic [8:0]    origin_y,
    input  logic [7:0]    advance,
    input  logic          full,
    output logic          push,
    output gqg_pkg::cmd_t cmd
);

    localparam logic [8:0] SLOTS = 9'(GLYPH_SLOTS);

    logic [8:0] slot9;
    logic       in_table;
    logic       keep;

    always_comb
    begin
        slot9    = {1'b0, char_code} - {1'b0, gqg_pkg::CHAR_FIRST};
        in_table = (char_code >= gqg_pkg::CHAR_FIRST) && (slot9 < SLOTS);

        cmd.start       = start_text;
        cmd.slot        = slot9[7:0];
        cmd.no_glyph    = !in_table;
        cmd.entry.ax    = atlas_x;
        cmd.entry.ay    = atlas_y;
        cmd.entry.gw    = glyph_width;
        cmd.entry.gh    = glyph_height;
        cmd.entry.ox    = origin_x;
        cmd.entry.oy    = origin_y;
        cmd.entry.adv   = advance;

        if (op == gqg_pkg::OP_LOAD)
        begin
            cmd.kind  = gqg_pkg::KIND_LOAD;
            cmd.start = 1'b0;
            keep      = in_table;
        end
        else if (char_code == gqg_pkg::CHAR_NEWLINE)
        begin
            cmd.kind = gqg_pkg::KIND_NEWLINE;
            keep     = 1'b1;
        end
        else if (char_code >= gqg_pkg::CHAR_FIRST && char_code <= gqg_pkg::CHAR_LAST)
        begin
            cmd.kind = gqg_pkg::KIND_CHAR;
            keep     = 1'b1;
        end
        else
        begin
            cmd.kind = gqg_pkg::KIND_OTHER;
            keep     = start_text;
        end
    end

    assign in_ready = !full;
    assign push     = in_valid && !full && keep;

endmodule

/* hw/rtl/gqg_back.sv */
// output side: glyph table, cursor, dividers and vertex emission
module gqg_back #(
    parameter int GLYPH_SLOTS = gqg_pkg::GLYPH_SLOTS_DEF,
    parameter int CURSOR_BITS = gqg_pkg::CURSOR_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  gqg_pkg::cmd_t cmd,
    output logic          pop,
    input  logic [7:0]    font_size,
    input  logic [12:0]   atlas_width,
    input  logic [12:0]   atlas_height,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    corner,
    output logic [25:0]   pos_x,
    output logic [25:0]   pos_y,
    output logic [16:0]   tex_u,
    output logic [16:0]   tex_v,
    output logic [15:0]   glyph_number,
    output logic          last
);

    localparam int AW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam int SW = CURSOR_BITS + 3;
    localparam int MW = SW - 1 + 8;
    localparam int QW = (MW > 26) ? MW : 26;
    localparam logic [CURSOR_BITS-1:0] CURSOR_MAX = '1;

    gqg_pkg::glyph_entry_t mem [GLYPH_SLOTS];
    gqg_pkg::glyph_entry_t rdata_reg;
    gqg_pkg::glyph_entry_t ent;

    gqg_pkg::back_state_t state_reg, state_next;

    logic [CURSOR_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [CURSOR_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [CURSOR_BITS-1:0] cy_base;
    logic [CURSOR_BITS:0]   cy_sum;
    logic [CURSOR_BITS:0]   cx_sum;
    logic [15:0]            count_reg, count_next;
    logic [2:0]             corner_reg, corner_next;
    logic                   no_glyph_reg;
    logic [7:0]             adv_reg;
    logic [15:0]            glyph_reg;
    logic [3:0]             neg_reg;

    logic                   div_start;
    logic [7:0]             den_pos;
    logic [12:0]            den_u;
    logic [12:0]            den_v;
    logic [SW-1:0]          sum   [4];
    logic [SW-1:0]          mag   [4];
    logic [MW-1:0]          pnum  [4];
    logic [MW-1:0]          pquo  [4];
    logic [12:0]            coord [4];
    logic [gqg_pkg::UV_NUM_W-1:0] uquo [4];
    logic [7:0]             pdone;
    logic                   is_right;
    logic                   is_bottom;
    logic [QW-1:0]          qx;
    logic [QW-1:0]          qy;
    logic [QW-1:0]          px;
    logic [QW-1:0]          py;
    logic [gqg_pkg::UV_NUM_W-1:0] qu;
    logic [gqg_pkg::UV_NUM_W-1:0] qv;

    // numerators of the four position lanes and four texcoord lanes, and their denominators
    always_comb
    begin
        ent = no_glyph_reg ? '0 : rdata_reg;
        sum[0] = {3'b0, cursor_x_reg} - {{(SW-9){ent.ox[8]}}, ent.ox};
        sum[1] = sum[0] + {{(SW-8){1'b0}}, ent.gw};
        sum[2] = {3'b0, cursor_y_reg} - {{(SW-9){ent.oy[8]}}, ent.oy};
        sum[3] = sum[2] + {{(SW-8){1'b0}}, ent.gh};
        for (int i = 0; i < 4; i++)
        begin
            mag[i]  = sum[i][SW-1] ? (~sum[i] + 1'b1) : sum[i];
            pnum[i] = {mag[i][SW-2:0], 8'b0};
        end
        coord[0] = {1'b0, ent.ax};
        coord[1] = {1'b0, ent.ax} + {5'b0, ent.gw};
        coord[2] = {1'b0, ent.ay};
        coord[3] = {1'b0, ent.ay} + {5'b0, ent.gh};
        den_pos  = (font_size == '0) ? 8'd1 : font_size;
        den_u    = (atlas_width == '0) ? 13'd1 : atlas_width;
        den_v    = (atlas_height == '0) ? 13'd1 : atlas_height;
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        gqg_div #(
            .NUM_W(MW),
            .DEN_W(8)
        ) u_pdiv (
            .clk  (clk),
            .rst_n(rst_n),
            .start(div_start),
            .num  (pnum[g]),
            .den  (den_pos),
            .done (pdone[g]),
            .quo  (pquo[g])
        );

        gqg_div #(
            .NUM_W(gqg_pkg::UV_NUM_W),
            .DEN_W(13)
        ) u_udiv (
            .clk  (clk),
            .rst_n(rst_n),
            .start(div_start),
            .num  ({coord[g], 16'b0}),
            .den  ((g < 2) ? den_u : den_v),
            .done (pdone[g+4]),
            .quo  (uquo[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gqg_pkg::ST_IDLE;
            cursor_x_reg <= '0;
            cursor_y_reg <= CURSOR_BITS'(gqg_pkg::FONT_SIZE_RST);
            count_reg    <= '0;
            corner_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            count_reg    <= count_next;
            corner_reg   <= corner_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        count_next    = count_reg;
        corner_next   = corner_reg;
        pop           = 1'b0;
        div_start     = 1'b0;
        out_valid     = 1'b0;
        cy_base       = cmd.start ? CURSOR_BITS'(font_size) : cursor_y_reg;
        cy_sum        = {1'b0, cy_base} + (CURSOR_BITS+1)'(font_size);
        cx_sum        = {1'b0, cursor_x_reg} + (CURSOR_BITS+1)'(adv_reg);
        case (state_reg)
            gqg_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (cmd.start)
                    begin
                        cursor_x_next = '0;
                        cursor_y_next = cy_base;
                        count_next    = '0;
                    end
                    if (cmd.kind == gqg_pkg::KIND_NEWLINE)
                    begin
                        cursor_x_next = '0;
                        cursor_y_next = cy_sum[CURSOR_BITS] ? CURSOR_MAX
                                                            : cy_sum[CURSOR_BITS-1:0];
                    end
                    if (cmd.kind == gqg_pkg::KIND_CHAR)
                    begin
                        state_next = gqg_pkg::ST_FETCH;
                    end
                end
            end
            gqg_pkg::ST_FETCH:
            begin
                div_start  = 1'b1;
                state_next = gqg_pkg::ST_DIV;
            end
            gqg_pkg::ST_DIV:
            begin
                if (&pdone)
                begin
                    corner_next = '0;
                    state_next  = gqg_pkg::ST_EMIT;
                end
            end
            gqg_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (corner_reg == gqg_pkg::CORNER_LAST)
                    begin
                        cursor_x_next = cx_sum[CURSOR_BITS] ? CURSOR_MAX
                                                            : cx_sum[CURSOR_BITS-1:0];
                        count_next    = count_reg + 16'd1;
                        state_next    = gqg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        corner_next = corner_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = gqg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop && cmd.kind == gqg_pkg::KIND_LOAD)
        begin
            mem[cmd.slot[AW-1:0]] <= cmd.entry;
        end
        if (pop && cmd.kind == gqg_pkg::KIND_CHAR)
        begin
            rdata_reg    <= mem[cmd.slot[AW-1:0]];
            no_glyph_reg <= cmd.no_glyph;
        end
        if (div_start)
        begin
            adv_reg   <= ent.adv;
            glyph_reg <= count_reg;
            for (int i = 0; i < 4; i++)
            begin
                neg_reg[i] <= sum[i][SW-1];
            end
        end
    end

    // corners in order tl, bl, tr, tr, bl, br
    always_comb
    begin
        is_right  = (corner_reg == 3'd2) || (corner_reg == 3'd3) ||
                    (corner_reg == gqg_pkg::CORNER_LAST);
        is_bottom = (corner_reg == 3'd1) || (corner_reg == 3'd4) ||
                    (corner_reg == gqg_pkg::CORNER_LAST);
        qx = QW'(is_right ? pquo[1] : pquo[0]);
        qy = QW'(is_bottom ? pquo[3] : pquo[2]);
        px = (is_right ? neg_reg[1] : neg_reg[0]) ? (~qx + 1'b1) : qx;
        py = (is_bottom ? neg_reg[3] : neg_reg[2]) ? (~qy + 1'b1) : qy;
        qu = is_right ? uquo[1] : uquo[0];
        qv = is_bottom ? uquo[3] : uquo[2];
    end

    assign corner       = corner_reg;
    assign pos_x        = px[25:0];
    assign pos_y        = py[25:0];
    assign tex_u        = (qu > 29'(gqg_pkg::UV_ONE)) ? gqg_pkg::UV_ONE : qu[16:0];
    assign tex_v        = (qv > 29'(gqg_pkg::UV_ONE)) ? gqg_pkg::UV_ONE : qv[16:0];
    assign glyph_number = glyph_reg;
    assign last         = (corner_reg == gqg_pkg::CORNER_LAST);

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> &pdone)
        else $error("divider started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == gqg_pkg::ST_IDLE)
        else $error("queue popped while a character is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> state_reg == gqg_pkg::ST_IDLE)
        else $error("quad did not finish after its last vertex");

endmodule

/* hw/rtl/glyph_quad_generator.sv */
// glyph quad generator top level: config registers, front, queue, back
// a load, newline or other code is handled in the back's idle state as it is popped
// a printable character goes through the fetch, divide and emit states; divide
// waits on the bit-serial dividers that scale positions and texcoords
// the front keeps accepting items into a two-entry queue meanwhile until it is full
// reset restores control state, cursor, count and config regs; not the glyph table
module glyph_quad_generator #(
    parameter int GLYPH_SLOTS = gqg_pkg::GLYPH_SLOTS_DEF,
    parameter int CURSOR_BITS = gqg_pkg::CURSOR_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // char_code[7:0], start_text[8], atlas_x[20:9], atlas_y[32:21], glyph_width[40:33],
    // glyph_height[48:41], origin_x[57:49], origin_y[66:58], advance[74:67], zero pad
    input  logic [79:0]  s_tdata,
    // op[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // corner[2:0], pos_x[28:3], pos_y[54:29], tex_u[71:55], tex_v[88:72],
    // glyph_number[104:89], zero pad
    output logic [111:0] m_tdata,
    output logic         m_tlast
);

    logic [7:0]  font_size_reg;
    logic [12:0] atlas_width_reg;
    logic [12:0] atlas_height_reg;
    logic [1:0]  reg_idx;

    gqg_pkg::cmd_t push_cmd;
    gqg_pkg::cmd_t pop_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    logic [2:0]  corner;
    logic [25:0] pos_x;
    logic [25:0] pos_y;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] glyph_number;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_size_reg    <= gqg_pkg::FONT_SIZE_RST;
            atlas_width_reg  <= gqg_pkg::ATLAS_WIDTH_RST;
            atlas_height_reg <= gqg_pkg::ATLAS_HEIGHT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                gqg_pkg::REG_FONT_SIZE:    font_size_reg    <= pwdata[7:0];
                gqg_pkg::REG_ATLAS_WIDTH:  atlas_width_reg  <= pwdata[12:0];
                gqg_pkg::REG_ATLAS_HEIGHT: atlas_height_reg <= pwdata[12:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gqg_pkg::REG_FONT_SIZE:    prdata = {24'b0, font_size_reg};
            gqg_pkg::REG_ATLAS_WIDTH:  prdata = {19'b0, atlas_width_reg};
            gqg_pkg::REG_ATLAS_HEIGHT: prdata = {19'b0, atlas_height_reg};
            default:                   prdata = '0;
        endcase
    end

    gqg_front #(
        .GLYPH_SLOTS(GLYPH_SLOTS)
    ) u_front (
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .op          (s_tuser),
        .char_code   (s_tdata[7:0]),
        .start_text  (s_tdata[8]),
        .atlas_x     (s_tdata[20:9]),
        .atlas_y     (s_tdata[32:21]),
        .glyph_width (s_tdata[40:33]),
        .glyph_height(s_tdata[48:41]),
        .origin_x    (s_tdata[57:49]),
        .origin_y    (s_tdata[66:58]),
        .advance     (s_tdata[74:67]),
        .full        (full),
        .push        (push),
        .cmd         (push_cmd)
    );

    gqg_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .pop_cmd (pop_cmd)
    );

    gqg_back #(
        .GLYPH_SLOTS(GLYPH_SLOTS),
        .CURSOR_BITS(CURSOR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .cmd         (pop_cmd),
        .pop         (pop),
        .font_size   (font_size_reg),
        .atlas_width (atlas_width_reg),
        .atlas_height(atlas_height_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .corner      (corner),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .glyph_number(glyph_number),
        .last        (m_tlast)
    );

    assign m_tdata = {7'b0, glyph_number, tex_v, tex_u, pos_y, pos_x, corner};

endmodule
